// ----- hdl/prtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_pkg - shared definitions of the peer range table trim unit
// field widths, command and status codes, transaction payload types
// ----------------------------------------------------------------------------
package prtt_pkg;

	// default table geometry
	localparam int PEERS_DEF  = 16;
	localparam int RANGES_DEF = 16;

	// fixed field widths
	localparam int CMD_W     = 2;
	localparam int SLOT_IN_W = 4;
	localparam int POS_W     = 48;
	localparam int TIME_W    = 40;
	localparam int OCNT_W    = 5;
	localparam int STAT_W    = 2;

	// internal entry counters, wide enough for the largest slot
	localparam int CNT_W = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRIM  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	// unused code, only reports the slot's counts
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [SLOT_IN_W-1:0] peer_slot;
		logic                 first_item;
		logic [POS_W-1:0]     range_begin;
		logic [POS_W-1:0]     range_end;
		logic [TIME_W-1:0]    now_time;
	} prtt_req_t;

	typedef struct packed {
		logic [OCNT_W-1:0] updated_count;
		logic [OCNT_W-1:0] entry_count;
		logic [STAT_W-1:0] status;
		logic [TIME_W-1:0] progress_stamp;
	} prtt_rsp_t;

endpackage

// ----- hdl/prtt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_req_if - request channel of the peer range table trim unit
// valid/ready handshake carrying one command transaction
// ----------------------------------------------------------------------------
interface prtt_req_if import prtt_pkg::*; ();

	logic      valid;
	logic      ready;
	prtt_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- hdl/prtt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_rsp_if - response channel of the peer range table trim unit
// valid/ready handshake carrying one result transaction
// ----------------------------------------------------------------------------
interface prtt_rsp_if import prtt_pkg::*; ();

	logic      valid;
	logic      ready;
	prtt_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- hdl/peer_range_table_trim_unit.sv -----
`timescale 1ns / 1ps
// The unit keeps, for each of PEERS peer slots, a list of up to RANGES requested
// byte ranges [begin,end). Every request to an existing slot walks that slot's
// entries one per cycle through a single compare unit fed by the range memories.
// A trim that splits entries then fetches the first split tail and visits the
// slot's entries in turn while placing tails into free entries. The request
// side is ready only while the sequencer is idle; a finished result sits in an
// output register so the next request can be taken before it is drained.
// No clearing pass is needed after reset: entry valid bits and per-slot progress
// valid bits are cleared by the reset itself.
// ----------------------------------------------------------------------------
// peer_range_table_trim_unit - per-peer byte range table with trimming
// load, trim by a completed range, clear; one result per request
// ----------------------------------------------------------------------------
module peer_range_table_trim_unit import prtt_pkg::*; #(
	parameter int PEERS  = PEERS_DEF,
	parameter int RANGES = RANGES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	prtt_req_if.sink  req,
	prtt_rsp_if.source rsp
);

	// table geometry
	localparam int SLOT_W = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int IDX_W  = (RANGES > 1) ? $clog2(RANGES) : 1;
	localparam int ENT    = PEERS * RANGES;
	localparam int ADDR_W = (ENT > 1) ? $clog2(ENT) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RANGES - 1);
	localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(RANGES);

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PREP,
		S_INS,
		S_DONE
	} state_t;

	// what the scan does with each entry of the slot
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TRIM,
		OP_CLEAR,
		OP_COUNT
	} op_t;

	state_t state_q;
	op_t    op_q;

	// latched request
	logic [POS_W-1:0]  b_q;
	logic [POS_W-1:0]  e_q;
	logic [TIME_W-1:0] now_q;
	logic              first_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] base_q;
	logic              slot_ok_q;
	logic [STAT_W-1:0] stat_q;

	// scan pipeline: read issue, then evaluate one entry a cycle
	logic [IDX_W:0]    rd_idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [POS_W-1:0]  beg_s1;
	logic [POS_W-1:0]  fin_s1;

	// tally and tail placement
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  upd_q;
	logic [CNT_W-1:0]  ntail_q;
	logic [CNT_W-1:0]  tpos_q;
	logic [IDX_W:0]    ins_idx_q;
	logic              found_q;
	logic [POS_W-1:0]  tail_rd_q;

	// entry valid bits and per-slot progress time
	logic [ENT-1:0]    valid_q;
	logic [PEERS-1:0]  prog_vld_q;
	logic              prog_hit_q;
	logic [TIME_W-1:0] prog_rd_q;

	// range memories and the split tail buffer
	logic [POS_W-1:0]  beg_mem [ENT];
	logic [POS_W-1:0]  fin_mem [ENT];
	logic [POS_W-1:0]  tail_mem [RANGES];
	logic [TIME_W-1:0] prog_mem [PEERS];

	// output register
	logic              rsp_valid_q;
	prtt_rsp_t         rsp_data_q;

	// acceptance decode
	logic              acc;
	logic [SLOT_W-1:0] acc_slot;
	logic              acc_ok;
	op_t               acc_op;
	logic [STAT_W-1:0] acc_stat;

	// per-entry datapath
	logic [ADDR_W-1:0] wa;
	logic [ADDR_W-1:0] ia;
	logic [ADDR_W-1:0] scan_ra;
	logic [IDX_W-1:0]  tail_ra;
	logic              v_cur;
	logic              e_gt_rb;
	logic              b_lt_re;
	logic              b_gt_rb;
	logic              e_lt_re;
	logic              re_le_rb;
	logic              overlap;

	logic              mem_we_b;
	logic              mem_we_e;
	logic [ADDR_W-1:0] mem_wa;
	logic [POS_W-1:0]  mem_wd_b;
	logic [POS_W-1:0]  mem_wd_e;
	logic              vld_we;
	logic              vld_wd;
	logic [ADDR_W-1:0] vld_wa;
	logic              tail_we;
	logic              cnt_inc;
	logic              upd_inc;
	logic              found_set;
	logic              placed;

	logic              scan_last;
	logic [CNT_W-1:0]  ntail_nxt;
	logic [CNT_W-1:0]  tpos_nxt;
	logic              done_fire;
	logic              stamp;
	logic              prog_we;
	prtt_rsp_t         result;

	// ------------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------------
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// slot numbers at or beyond PEERS address nothing
	assign acc_slot = SLOT_W'(req.data.peer_slot);
	assign acc_ok   = (9'(req.data.peer_slot) < 9'(PEERS));

	// an empty or inverted trim range only counts the slot
	always_comb begin
		acc_stat = ST_OK;
		unique case (req.data.command)
			CMD_LOAD: begin
				acc_op = OP_LOAD;
			end
			CMD_TRIM: begin
				if (req.data.range_end > req.data.range_begin) begin
					acc_op = OP_TRIM;
				end else begin
					acc_op   = OP_COUNT;
					acc_stat = ST_EMPTY;
				end
			end
			CMD_CLEAR: begin
				acc_op = OP_CLEAR;
			end
			default: begin
				acc_op = OP_COUNT;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// addresses
	// ------------------------------------------------------------------------
	assign wa      = base_q + ADDR_W'(idx_s1);
	assign ia      = base_q + ADDR_W'(ins_idx_q[IDX_W-1:0]);
	assign scan_ra = base_q + ADDR_W'(rd_idx_q[IDX_W-1:0]);
	assign v_cur   = valid_q[wa];

	// ------------------------------------------------------------------------
	// shared compare unit: stored entry against the completed range
	// ------------------------------------------------------------------------
	assign e_gt_rb  = (e_q > beg_s1);
	assign b_lt_re  = (b_q < fin_s1);
	assign b_gt_rb  = (b_q > beg_s1);
	assign e_lt_re  = (e_q < fin_s1);
	assign re_le_rb = (fin_s1 <= beg_s1);
	assign overlap  = e_gt_rb && b_lt_re;

	// per-entry action during the scan and the tail placement
	always_comb begin
		mem_we_b  = 1'b0;
		mem_we_e  = 1'b0;
		mem_wa    = wa;
		mem_wd_b  = b_q;
		mem_wd_e  = e_q;
		vld_we    = 1'b0;
		vld_wd    = 1'b0;
		vld_wa    = wa;
		tail_we   = 1'b0;
		cnt_inc   = 1'b0;
		upd_inc   = 1'b0;
		found_set = 1'b0;
		placed    = 1'b0;
		if (state_q == S_SCAN && vld_s1) begin
			unique case (op_q)
				OP_LOAD: begin
					// a first item empties the list while the new range lands
					// in the first free entry
					if (v_cur && !first_q) begin
						cnt_inc = 1'b1;
					end else if (!found_q) begin
						mem_we_b  = 1'b1;
						mem_we_e  = 1'b1;
						vld_we    = 1'b1;
						vld_wd    = 1'b1;
						cnt_inc   = 1'b1;
						found_set = 1'b1;
					end else begin
						vld_we = 1'b1;
					end
				end
				OP_TRIM: begin
					if (v_cur) begin
						if (overlap) begin
							upd_inc = 1'b1;
							priority if (!b_gt_rb && e_lt_re) begin
								// front cut
								mem_we_b = 1'b1;
								mem_wd_b = e_q;
								cnt_inc  = 1'b1;
							end else if (b_gt_rb && !e_lt_re) begin
								// back cut
								mem_we_e = 1'b1;
								mem_wd_e = b_q;
								cnt_inc  = 1'b1;
							end else if (b_gt_rb && e_lt_re) begin
								// split, tail kept for later placement
								mem_we_e = 1'b1;
								mem_wd_e = b_q;
								tail_we  = 1'b1;
								cnt_inc  = 1'b1;
							end else begin
								vld_we = 1'b1;
							end
						end else if (re_le_rb) begin
							// empty entry left over from a load
							vld_we = 1'b1;
						end else begin
							cnt_inc = 1'b1;
						end
					end
				end
				OP_CLEAR: begin
					vld_we = 1'b1;
				end
				OP_COUNT: begin
					cnt_inc = v_cur;
				end
				default: begin
					cnt_inc = 1'b0;
				end
			endcase
		end else if (state_q == S_INS) begin
			mem_wa   = ia;
			vld_wa   = ia;
			mem_wd_b = e_q;
			mem_wd_e = tail_rd_q;
			if (!valid_q[ia]) begin
				mem_we_b = 1'b1;
				mem_we_e = 1'b1;
				vld_we   = 1'b1;
				vld_wd   = 1'b1;
				cnt_inc  = 1'b1;
				placed   = 1'b1;
			end
		end
	end

	assign scan_last = vld_s1 && (idx_s1 == LAST_IDX);
	assign ntail_nxt = ntail_q + CNT_W'(tail_we);
	assign tpos_nxt  = tpos_q + CNT_W'(placed);
	assign tail_ra   = tpos_nxt[IDX_W-1:0];
	assign done_fire = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// progress time: any load with a time, or a trim that changed entries
	assign stamp = slot_ok_q &&
		((op_q == OP_LOAD && now_q != '0) || (op_q == OP_TRIM && upd_q != '0));
	assign prog_we = done_fire && stamp;

	// result, saturating counts; an out-of-range slot reports all zero
	always_comb begin
		result = '0;
		if (slot_ok_q) begin
			result.updated_count  = (upd_q > CNT_W'(31)) ? OCNT_W'(31) : upd_q[OCNT_W-1:0];
			result.entry_count    = (cnt_q > CNT_W'(31)) ? OCNT_W'(31) : cnt_q[OCNT_W-1:0];
			result.status         = stat_q;
			result.progress_stamp = stamp ? now_q : (prog_hit_q ? prog_rd_q : '0);
		end
	end

	// ------------------------------------------------------------------------
	// request latch
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (acc) begin
			b_q     <= req.data.range_begin;
			e_q     <= req.data.range_end;
			now_q   <= req.data.now_time;
			first_q <= req.data.first_item;
			slot_q  <= acc_slot;
			base_q  <= ADDR_W'(int'(acc_slot) * RANGES);
		end
	end

	// ------------------------------------------------------------------------
	// memories, registered reads
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we_b) begin
			beg_mem[mem_wa] <= mem_wd_b;
		end
		if (mem_we_e) begin
			fin_mem[mem_wa] <= mem_wd_e;
		end
		beg_s1 <= beg_mem[scan_ra];
		fin_s1 <= fin_mem[scan_ra];
		if (tail_we) begin
			tail_mem[ntail_q[IDX_W-1:0]] <= fin_s1;
		end
		tail_rd_q <= tail_mem[tail_ra];
		if (prog_we) begin
			prog_mem[slot_q] <= now_q;
		end
		if (acc) begin
			prog_rd_q <= prog_mem[acc_slot];
		end
	end

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_COUNT;
			slot_ok_q   <= 1'b0;
			stat_q      <= ST_OK;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			cnt_q       <= '0;
			upd_q       <= '0;
			ntail_q     <= '0;
			tpos_q      <= '0;
			ins_idx_q   <= '0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			prog_vld_q  <= '0;
			prog_hit_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			// a result loaded this cycle keeps the output valid
			if (rsp_valid_q && rsp.ready && !done_fire) begin
				rsp_valid_q <= 1'b0;
			end
			if (vld_we) begin
				valid_q[vld_wa] <= vld_wd;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= acc_op;
						stat_q     <= acc_stat;
						slot_ok_q  <= acc_ok;
						prog_hit_q <= prog_vld_q[acc_slot];
						rd_idx_q   <= '0;
						vld_s1     <= 1'b0;
						cnt_q      <= '0;
						upd_q      <= '0;
						ntail_q    <= '0;
						tpos_q     <= '0;
						ins_idx_q  <= '0;
						found_q    <= 1'b0;
						state_q    <= acc_ok ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					// issue one read a cycle, evaluate it the next; the last
					// entry is evaluated once all reads are issued
					if (rd_idx_q != SCAN_END) begin
						idx_s1   <= rd_idx_q[IDX_W-1:0];
						vld_s1   <= 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					cnt_q   <= cnt_q + CNT_W'(cnt_inc);
					upd_q   <= upd_q + CNT_W'(upd_inc);
					ntail_q <= ntail_nxt;
					found_q <= found_q || found_set;
					if (scan_last) begin
						if (op_q == OP_LOAD && !found_q && !found_set) begin
							stat_q <= ST_FULL;
						end
						state_q <= (ntail_nxt != '0) ? S_PREP : S_DONE;
					end
				end
				S_PREP: begin
					// first split tail is being fetched
					state_q <= S_INS;
				end
				S_INS: begin
					ins_idx_q <= ins_idx_q + 1'b1;
					tpos_q    <= tpos_nxt;
					cnt_q     <= cnt_q + CNT_W'(cnt_inc);
					if (tpos_nxt == ntail_q) begin
						state_q <= S_DONE;
					end else if (ins_idx_q[IDX_W-1:0] == LAST_IDX) begin
						// tails left with no free entry are dropped
						stat_q  <= ST_FULL;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= result;
						if (stamp) begin
							prog_vld_q[slot_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
